// File: rtl/core/softmax_cross_entropy_macros.svh
// Assertion helpers shared by the core
`ifndef SOFTMAX_CROSS_ENTROPY_MACROS_SVH
`define SOFTMAX_CROSS_ENTROPY_MACROS_SVH
`ifndef SYNTHESIS
`define SCE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("sce check failed");
`define SCE_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `SCE_ASSERT(lbl, clk, rstn, !(cond))
`else
`define SCE_ASSERT(lbl, clk, rstn, prop)
`define SCE_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// File: rtl/core/sce_pkg.sv
`timescale 1ns / 1ps
package sce_pkg;

  localparam int MAX_CLASSES_DEF    = 32;
  localparam int EXP_TABLE_BITS_DEF = 10;

  localparam int LOGIT_W   = 16;
  localparam int CLS_IDX_W = 6;
  localparam int VAL_W     = 24;
  localparam int ACC_W     = 40;
  localparam int DIV_NUM_W = 41;
  localparam int DIV_K_W   = $clog2(DIV_NUM_W + 1);

  localparam logic [32:0] LOG2E_Q16 = 33'd94548;
  localparam logic [39:0] LN2_Q16   = 40'd45426;
  localparam longint unsigned LN2_Q30 = 64'd744261118;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic                        en;
    logic                        bank;
    logic [CLS_IDX_W-1:0]        addr;
    logic signed [LOGIT_W-1:0]   logit;
    logic                        label;
  } mem_wr_t;

  typedef struct packed {
    logic                        bank;
    logic [CLS_IDX_W-1:0]        count;
    logic signed [LOGIT_W-1:0]   row_max;
    logic signed [LOGIT_W-1:0]   true_logit;
    logic                        batch_end;
  } row_desc_t;

  // 2^(-i/2^eb) in Q16, Taylor series in Q30
  function automatic logic [16:0] exp_entry(input int unsigned i, input int unsigned eb);
    longint unsigned x, y, term, pos, neg;
    x    = 64'(i) << (30 - eb);
    y    = (x * LN2_Q30) >> 30;
    term = ONE_Q30;
    pos  = ONE_Q30;
    neg  = 64'd0;
    for (int k = 1; k <= 14; k++) begin
      term = ((term * y) >> 30) / 64'(k);
      if (k % 2 == 1) neg = neg + term;
      else            pos = pos + term;
    end
    return 17'((pos - neg + 64'd8192) >> 14);
  endfunction

  // log2(1 + i/2^eb) in Q16, by repeated squaring in Q30
  function automatic logic [16:0] log_entry(input int unsigned i, input int unsigned eb);
    longint unsigned x, r;
    x = (64'(1 << eb) + 64'(i)) << (30 - eb);
    r = 64'd0;
    for (int k = 1; k <= 20; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r = r | (64'd1 << (20 - k));
      end
    end
    return 17'((r + 64'd8) >> 4);
  endfunction

endpackage

// File: rtl/core/sce_in_if.sv
`timescale 1ns / 1ps
interface sce_in_if;
  logic        valid;
  logic        ready;
  logic signed [15:0] logit;
  logic        is_true_class;
  logic        last_in_row;
  logic        last_in_batch;

  modport source (output valid, logit, is_true_class, last_in_row, last_in_batch,
                  input ready);
  modport sink   (input valid, logit, is_true_class, last_in_row, last_in_batch,
                  output ready);
endinterface

// File: rtl/core/sce_out_if.sv
`timescale 1ns / 1ps
interface sce_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [5:0]  class_index;
  logic signed [23:0] result_value;
  logic        last_result;

  modport source (output valid, result_kind, class_index, result_value, last_result,
                  input ready);
  modport sink   (input valid, result_kind, class_index, result_value, last_result,
                  output ready);
endinterface

// File: rtl/core/sce_front.sv
`timescale 1ns / 1ps
module sce_front #(
  parameter int MAX_CLASSES = sce_pkg::MAX_CLASSES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sce_in_if.sink              in_i,
  input  logic                q_full_i,
  output logic                push_o,
  output sce_pkg::row_desc_t  desc_o,
  output sce_pkg::mem_wr_t    wr_o
);

  logic [sce_pkg::CLS_IDX_W-1:0] cnt_q, cnt_n;
  logic signed [15:0]            max_q, max_n, tru_q, tru_n;
  logic                          bank_q;
  logic                          beat, store;

  assign in_i.ready = !q_full_i;
  assign beat  = in_i.valid && in_i.ready;
  // overflow logits are dropped, marks still count
  assign store = cnt_q < sce_pkg::CLS_IDX_W'(MAX_CLASSES);

  always_comb begin
    cnt_n = store ? cnt_q + sce_pkg::CLS_IDX_W'(1) : cnt_q;
    max_n = (store && (in_i.logit > max_q)) ? in_i.logit : max_q;
    tru_n = (store && in_i.is_true_class) ? in_i.logit : tru_q;
  end

  always_comb begin
    wr_o.en    = beat && store;
    wr_o.bank  = bank_q;
    wr_o.addr  = cnt_q;
    wr_o.logit = in_i.logit;
    wr_o.label = in_i.is_true_class;
    push_o            = beat && in_i.last_in_row;
    desc_o.bank       = bank_q;
    desc_o.count      = cnt_n;
    desc_o.row_max    = max_n;
    desc_o.true_logit = tru_n;
    desc_o.batch_end  = in_i.last_in_batch;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      max_q  <= 16'sh8000;
      tru_q  <= '0;
      bank_q <= 1'b0;
    end else if (beat) begin
      if (in_i.last_in_row) begin
        cnt_q  <= '0;
        max_q  <= 16'sh8000;
        tru_q  <= '0;
        bank_q <= !bank_q;
      end else begin
        cnt_q <= cnt_n;
        max_q <= max_n;
        tru_q <= tru_n;
      end
    end
  end

endmodule

// File: rtl/core/sce_queue.sv
`timescale 1ns / 1ps
module sce_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sce_pkg::row_desc_t  push_data_i,
  input  logic                pop_i,
  output sce_pkg::row_desc_t  head_o,
  output logic                full_o,
  output logic                empty_o
);

  sce_pkg::row_desc_t ent_q [2];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;

  assign head_o  = ent_q[rp_q];
  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop_i)  rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// File: rtl/core/sce_div.sv
`timescale 1ns / 1ps
module sce_div #(
  parameter int NUM_W = sce_pkg::DIV_NUM_W,
  parameter int DEN_W = 22,
  localparam int KW   = $clog2(NUM_W + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [KW-1:0]    k_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  // restoring, one quotient bit a cycle; num_i >> k_i must be below den_i
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] num_q, quo_q;
  logic [KW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   r2;
  logic             ge;

  assign r2     = {rem_q, num_q[NUM_W-1]};
  assign ge     = r2 >= {1'b0, den_q};
  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= DEN_W'(num_i >> k_i);
      num_q <= num_i << (KW'(NUM_W) - k_i);
      quo_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? DEN_W'(r2 - {1'b0, den_q}) : DEN_W'(r2);
      num_q <= num_q << 1;
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= k_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - KW'(1);
        if (cnt_q == KW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/core/sce_back.sv
`timescale 1ns / 1ps
`include "softmax_cross_entropy_macros.svh"
module sce_back #(
  parameter int MAX_CLASSES    = sce_pkg::MAX_CLASSES_DEF,
  parameter int EXP_TABLE_BITS = sce_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i,
  input  sce_pkg::mem_wr_t    wr_i,
  input  sce_pkg::row_desc_t  job_i,
  input  logic                job_vld_i,
  output logic                job_pop_o,
  sce_out_if.source           out_o
);

  localparam int CLS_W = $clog2(MAX_CLASSES);
  localparam int SUM_W = 16 + $clog2(MAX_CLASSES + 1);
  localparam int TAB   = 1 << EXP_TABLE_BITS;
  localparam int SH_W  = $clog2(SUM_W);
  localparam int NW    = sce_pkg::DIV_NUM_W;
  localparam int KW    = sce_pkg::DIV_K_W;
  localparam int CW    = sce_pkg::CLS_IDX_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_ROM, S_EXP, S_NORM, S_LOG,
    S_DIVQ, S_DIVG, S_GOUT, S_LOSS, S_DIVL, S_LOUT
  } state_e;

  state_e state_q;

  // row store, two banks
  logic [16:0] mem [2 * (1 << CLS_W)];
  logic [16:0] rd_q;
  logic [16:0] exp_rom [TAB];
  logic [16:0] log_rom [TAB];
  logic [16:0] exp_rd_q, log_rd_q;

  logic [CLS_W-1:0] i_q;
  logic             pass_q, lab_q, neg_q;
  logic [32:0]      t_q;
  logic [8:0]       n_q;
  logic [SUM_W-1:0] sum_q, norm_q;
  logic [SH_W-1:0]  sh_q;
  logic [19:0]      ln_q;
  logic [23:0]      val_q;
  logic signed [39:0] acc_q;
  logic [15:0]      batch_q;

  logic        out_vld_q, out_kind_q, out_last_q;
  logic [CW-1:0] out_cls_q;
  logic [23:0] out_val_q;

  logic          div_start, div_busy, div_done;
  logic [NW-1:0] div_num, div_quo;
  logic [SUM_W-1:0] div_den;
  logic [KW-1:0] div_k;

  logic [15:0]        div_u;
  logic signed [16:0] d_s;
  logic [16:0]        e_val;
  logic signed [18:0] g_s;
  logic [16:0]        g_mag;
  logic [7:0]         pm;
  logic [23:0]        l2;
  logic [19:0]        ln_n;
  logic signed [16:0] diff;
  logic signed [41:0] acc_sum;
  logic signed [39:0] acc_sat;
  logic signed [40:0] acc_w;
  logic [40:0]        acc_mag;
  logic               last_i, out_free, out_load;

  function automatic logic [23:0] sat24(input logic neg, input logic [40:0] mag);
    if (!neg) return (mag > 41'd8388607) ? 24'h7FFFFF : mag[23:0];
    return (mag > 41'd8388608) ? 24'h800000 : 24'(~mag[23:0] + 24'd1);
  endfunction

  for (genvar g = 0; g < TAB; g++) begin : g_rom
    assign exp_rom[g] = sce_pkg::exp_entry(g, EXP_TABLE_BITS);
    assign log_rom[g] = sce_pkg::log_entry(g, EXP_TABLE_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[{wr_i.bank, wr_i.addr[CLS_W-1:0]}] <= {wr_i.label, wr_i.logit};
    rd_q     <= mem[{job_i.bank, i_q}];
    exp_rd_q <= exp_rom[t_q[23 -: EXP_TABLE_BITS]];
    log_rd_q <= log_rom[norm_q[SUM_W-2 -: EXP_TABLE_BITS]];
  end

  always_comb begin
    div_u    = (batch_q == 16'd0) ? 16'd1 : batch_q;
    d_s      = 17'(job_i.row_max) - 17'($signed(rd_q[15:0]));
    e_val    = (n_q >= 9'd32) ? 17'd0 : (exp_rd_q >> n_q[4:0]);
    g_s      = $signed({2'b00, div_quo[16:0]}) - (lab_q ? 19'sd65536 : 19'sd0);
    g_mag    = g_s[18] ? 17'(-g_s) : 17'(g_s);
    pm       = 8'(SUM_W - 17) - 8'(sh_q);
    l2       = (24'(pm) << 16) + 24'(log_rd_q);
    ln_n     = 20'(((40'(l2) * sce_pkg::LN2_Q16) + 40'd32768) >> 16);
    diff     = 17'(job_i.row_max) - 17'(job_i.true_logit);
    acc_sum  = 42'(acc_q) + (42'(diff) <<< 8) + 42'($signed({1'b0, ln_q}));
    if (acc_sum > 42'sd549755813887)       acc_sat = 40'sh7FFFFFFFFF;
    else if (acc_sum < -42'sd549755813888) acc_sat = 40'sh8000000000;
    else                                   acc_sat = 40'(acc_sum);
    acc_w    = 41'(acc_sat);
    acc_mag  = acc_w[40] ? 41'(-acc_w) : 41'(acc_w);
    last_i   = (CW'(i_q) + CW'(1)) == job_i.count;
    out_free = !out_vld_q || out_o.ready;
    out_load = ((state_q == S_GOUT) || (state_q == S_LOUT)) && out_free;
  end

  // divider sharing: softmax quotient, gradient scaling, mean loss
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = SUM_W'(div_u);
    div_k     = KW'(17);
    case (state_q)
      S_EXP: begin
        if (pass_q) begin
          div_start = 1'b1;
          div_num   = (NW'(e_val) << 16) + NW'(sum_q >> 1);
          div_den   = sum_q;
        end
      end
      S_DIVQ: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = NW'(g_mag) + NW'(div_u >> 1);
        end
      end
      S_LOSS: begin
        if (job_i.batch_end) begin
          div_start = 1'b1;
          div_num   = NW'(acc_mag) + NW'(div_u >> 1);
          div_k     = KW'(sce_pkg::ACC_W);
        end
      end
      default: ;
    endcase
  end

  sce_div #(.NUM_W(NW), .DEN_W(SUM_W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(div_den), .k_i(div_k),
    .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  assign job_pop_o = ((state_q == S_LOSS) && !job_i.batch_end) ||
                     ((state_q == S_LOUT) && out_free);

  assign out_o.valid        = out_vld_q;
  assign out_o.result_kind  = out_kind_q;
  assign out_o.class_index  = out_cls_q;
  assign out_o.result_value = $signed(out_val_q);
  assign out_o.last_result  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      acc_q     <= '0;
      batch_q   <= 16'd1;
      pass_q    <= 1'b0;
      i_q       <= '0;
    end else begin
      if (cfg_we_i) batch_q <= cfg_wdata_i;
      if (out_load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (job_vld_i) begin
            i_q     <= '0;
            sum_q   <= '0;
            pass_q  <= 1'b0;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_MUL;
        S_MUL: begin
          t_q     <= 33'(d_s[15:0]) * sce_pkg::LOG2E_Q16;
          lab_q   <= rd_q[16];
          state_q <= S_ROM;
        end
        S_ROM: begin
          n_q     <= t_q[32:24];
          state_q <= S_EXP;
        end
        S_EXP: begin
          if (pass_q) begin
            state_q <= S_DIVQ;
          end else begin
            sum_q <= sum_q + SUM_W'(e_val);
            if (last_i) begin
              norm_q  <= sum_q + SUM_W'(e_val);
              sh_q    <= '0;
              state_q <= S_NORM;
            end else begin
              i_q     <= i_q + CLS_W'(1);
              state_q <= S_RD;
            end
          end
        end
        S_NORM: begin
          if (!norm_q[SUM_W-1]) begin
            norm_q <= norm_q << 1;
            sh_q   <= sh_q + SH_W'(1);
          end else begin
            state_q <= S_LOG;
          end
        end
        S_LOG: begin
          ln_q    <= ln_n;
          i_q     <= '0;
          pass_q  <= 1'b1;
          state_q <= S_RD;
        end
        S_DIVQ: begin
          if (div_done) begin
            neg_q   <= g_s[18];
            state_q <= S_DIVG;
          end
        end
        S_DIVG: begin
          if (div_done) begin
            val_q   <= sat24(neg_q, div_quo);
            state_q <= S_GOUT;
          end
        end
        S_GOUT: begin
          if (out_free) begin
            out_kind_q <= 1'b0;
            out_cls_q  <= CW'(i_q);
            out_val_q  <= val_q;
            out_last_q <= !job_i.batch_end && last_i;
            if (last_i) begin
              state_q <= S_LOSS;
            end else begin
              i_q     <= i_q + CLS_W'(1);
              state_q <= S_RD;
            end
          end
        end
        S_LOSS: begin
          acc_q <= acc_sat;
          if (job_i.batch_end) begin
            neg_q   <= acc_sat[39];
            state_q <= S_DIVL;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_DIVL: begin
          if (div_done) begin
            val_q   <= sat24(neg_q, div_quo);
            state_q <= S_LOUT;
          end
        end
        S_LOUT: begin
          if (out_free) begin
            out_kind_q <= 1'b1;
            out_cls_q  <= '0;
            out_val_q  <= val_q;
            out_last_q <= 1'b1;
            acc_q      <= '0;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SCE_ASSERT(a_job_held, clk_i, rst_ni, (state_q != S_IDLE) |-> job_vld_i)
  `SCE_ASSERT_NEVER(a_div_overlap, clk_i, rst_ni, div_start && div_busy)
  `SCE_ASSERT(a_sum_floor, clk_i, rst_ni, (state_q == S_NORM) |-> (sum_q >= SUM_W'(65536)))

endmodule

// File: rtl/core/softmax_cross_entropy.sv
`timescale 1ns / 1ps
// Softmax cross-entropy loss and gradient engine.
// in_i : one Q8.8 logit per beat with its one-hot label bit, an end-of-row and
//        an end-of-batch mark. out_o : Q8.16 results, saturated to 24 bits.
// cfg  : cfg_we_i/cfg_wdata_i write batch_rows (0 acts as 1); write only when idle.
// A row of N classes gives N gradient beats in class order; a batch end adds
// one mean-loss beat. last_result marks the final beat caused by an input.
// Throughput: inputs take one beat a cycle while the row queue (two rows, one
// per store bank) has room. The back end steps each element of a row through
// the read, multiply, table and exponential states for the exponential pass,
// normalises the sum by shifting and takes its log, then repeats the element
// steps for the gradient pass with the shared one-bit-a-cycle divider (17
// steps for the softmax, 17 for batch scaling), and at batch end divides the
// accumulated loss for the mean; it works on one row at a time.
// Reset: batch_rows=1, accumulator and row state cleared, no clearing pass.
// A stalled receiver holds the output register; the back end then waits, and
// the front keeps taking beats until the queue fills.
module softmax_cross_entropy #(
  parameter int MAX_CLASSES    = sce_pkg::MAX_CLASSES_DEF,
  parameter int EXP_TABLE_BITS = sce_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sce_in_if.sink      in_i,
  sce_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  sce_pkg::row_desc_t push_desc, head_desc;
  sce_pkg::mem_wr_t   wr;
  logic               push, pop, q_full, q_empty;

  // front: classify beats, fill the store, track max and true logit
  sce_front #(.MAX_CLASSES(MAX_CLASSES)) u_front (
    .clk_i, .rst_ni, .in_i,
    .q_full_i(q_full), .push_o(push), .desc_o(push_desc), .wr_o(wr)
  );

  // row descriptors between front and back
  sce_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_desc), .pop_i(pop),
    .head_o(head_desc), .full_o(q_full), .empty_o(q_empty)
  );

  // back: exponentials, log-sum-exp, gradients and loss
  sce_back #(.MAX_CLASSES(MAX_CLASSES), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .wr_i(wr), .job_i(head_desc), .job_vld_i(!q_empty), .job_pop_o(pop),
    .out_o
  );

endmodule

// File: test/softmax_cross_entropy_tb.sv
`timescale 1ns / 1ps
// Softmax cross-entropy engine bench.
// Beats go through the sce_in_if / sce_out_if handshakes, and a scoreboard
// object works out the expected results from its own model of the row/batch
// arithmetic.
module softmax_cross_entropy_tb;

  localparam int NCLS = sce_pkg::MAX_CLASSES_DEF;
  localparam int EB   = sce_pkg::EXP_TABLE_BITS_DEF;
  localparam int TABN = 1 << EB;

  typedef enum logic {KIND_GRAD = 1'b0, KIND_LOSS = 1'b1} kind_e;

  typedef struct packed {
    logic              kind;
    logic [5:0]        cls;
    logic signed [23:0] val;
    logic              last;
  } res_t;

  // Own copies of the exponent and log tables, built here
  longint unsigned exp_lut [TABN];
  longint unsigned log_lut [TABN];

  function automatic void build_luts();
    longint unsigned x, y, term, pos, neg, r;
    for (int i = 0; i < TABN; i++) begin
      x = longint'(i) << (30 - EB);
      y = (x * 64'd744261118) >> 30;
      term = 64'd1 << 30;
      pos = term;
      neg = 0;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * y) >> 30) / k;
        if (k % 2 == 1) neg += term;
        else pos += term;
      end
      exp_lut[i] = (pos - neg + 8192) >> 14;
      x = (longint'(TABN) + i) << (30 - EB);
      r = 0;
      for (int k = 1; k <= 20; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          r |= 64'd1 << (20 - k);
        end
      end
      log_lut[i] = (r + 8) >> 4;
    end
  endfunction

  function automatic longint round_div(longint v, int unsigned d);
    longint unsigned mag, q;
    if (d == 0) d = 1;
    mag = v < 0 ? -v : v;
    q = (mag + d / 2) / d;
    return v < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [23:0] clip24(longint v);
    if (v > 8388607) return 24'sd8388607;
    if (v < -8388608) return -24'sd8388608;
    return v[23:0];
  endfunction

  class loss_scoreboard;
    int unsigned batch_rows = 1;
    int          logits [NCLS];
    bit          labels [NCLS];
    int          row_max = -32768;
    int          true_logit = 0;
    int          count = 0;
    longint      loss_acc = 0;
    res_t        pending [$];
    int          errors = 0;

    function void note_beat(logic signed [15:0] lg, bit lab, bit eor, bit eob);
      longint unsigned e [NCLS];
      longint unsigned sum, d, t, n, l2, ln, q;
      int p, idx;
      longint g, row_loss;
      bit bend;
      int unsigned dv;
      res_t r;
      bend = eor && eob;
      dv = batch_rows == 0 ? 1 : batch_rows;
      if (count < NCLS) begin
        logits[count] = lg;
        labels[count] = lab;
        if (lg > row_max) row_max = lg;
        if (lab) true_logit = lg;
        count++;
      end
      if (!eor) return;
      sum = 0;
      for (int i = 0; i < count; i++) begin
        d = row_max - logits[i];
        t = d * 94548;
        n = t >> 24;
        idx = (t >> (24 - EB)) & (TABN - 1);
        e[i] = n >= 32 ? 0 : exp_lut[idx] >> n;
        sum += e[i];
      end
      if (sum == 0) sum = 1;
      p = 0;
      while (p < 63 && (sum >> (p + 1)) != 0) p++;
      if (p >= EB) idx = (sum >> (p - EB)) & (TABN - 1);
      else idx = (sum << (EB - p)) & (TABN - 1);
      l2 = (longint'(p >= 16 ? p - 16 : 0) << 16) + log_lut[idx];
      ln = (l2 * 45426 + 32768) >> 16;
      for (int i = 0; i < count; i++) begin
        q = ((e[i] << 16) + sum / 2) / sum;
        g = longint'(q) - (labels[i] ? 65536 : 0);
        r.kind = KIND_GRAD;
        r.cls = i[5:0];
        r.val = clip24(round_div(g, dv));
        r.last = !bend && (i + 1 == count);
        pending.push_back(r);
      end
      row_loss = longint'(row_max - true_logit) * 256 + longint'(ln);
      loss_acc += row_loss;
      if (loss_acc > 64'sd549755813887) loss_acc = 64'sd549755813887;
      if (loss_acc < -64'sd549755813888) loss_acc = -64'sd549755813888;
      count = 0;
      row_max = -32768;
      true_logit = 0;
      if (bend) begin
        r.kind = KIND_LOSS;
        r.cls = '0;
        r.val = clip24(round_div(loss_acc, dv));
        r.last = 1'b1;
        pending.push_back(r);
        loss_acc = 0;
      end
    endfunction

    function void check_beat(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat, got %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        $display("%0t: kind exp %0d act %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.cls !== want.cls) begin
        $display("%0t: class exp %0d act %0d", $time, want.cls, got.cls);
        errors++;
      end
      if (got.val !== want.val) begin
        $display("%0t: value exp %0d act %0d", $time, want.val, got.val);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last exp %0d act %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  sce_in_if  in_if ();
  sce_out_if out_if ();

  softmax_cross_entropy u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if.sink),
    .out_o       (out_if.source),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  loss_scoreboard sb = new();
  bit stim_done = 1'b0;
  int hold_off = 0;   // long receiver stall, in cycles

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.logit = '0;
    in_if.is_true_class = 1'b0;
    in_if.last_in_row = 1'b0;
    in_if.last_in_batch = 1'b0;
    out_if.ready = 1'b0;
  end

  // Input beats are noted in the scoreboard at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.note_beat(in_if.logit, in_if.is_true_class, in_if.last_in_row,
                   in_if.last_in_batch);
    end
  end

  // Receiver: random stall per beat, or a long hold-off when asked
  initial begin
    int gap;
    res_t got;
    @(posedge rst_ni);
    forever begin
      if (hold_off > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      got.kind = out_if.result_kind;
      got.cls  = out_if.class_index;
      got.val  = out_if.result_value;
      got.last = out_if.last_result;
      sb.check_beat(got);
    end
  end

  bit burst;   // run of back-to-back beats

  task automatic send_beat(logic signed [15:0] lg, bit lab, bit eor, bit eob);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.logit <= lg;
    in_if.is_true_class <= lab;
    in_if.last_in_row <= eor;
    in_if.last_in_batch <= eob;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Let every expected beat drain, then the back end settle
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_batch_rows(logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.batch_rows = v;
  endtask

  // One row of n classes with random logits spread limited by span
  task automatic send_row(int n, int span, bit eob);
    int tc;
    int base;
    logic signed [15:0] lg;
    tc = $urandom_range(0, n - 1);
    base = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < n; i++) begin
      lg = 16'(base + $urandom_range(0, span) - span / 2);
      if (span == 65535) lg = 16'($urandom);
      send_beat(lg, i == tc, i == n - 1, (i == n - 1) && eob);
    end
  endtask

  initial begin
    int rows, n;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    build_luts();
    @(posedge clk_i);

    // Directed: extremes, no true class, several true classes, stray batch mark
    burst = 1'b0;
    send_beat(16'sh7FFF, 1'b1, 1'b0, 1'b1);
    send_beat(-16'sh8000, 1'b0, 1'b0, 1'b0);
    send_beat(16'sh0000, 1'b0, 1'b1, 1'b0);
    send_beat(16'sh0100, 1'b0, 1'b0, 1'b0);
    send_beat(16'sh0100, 1'b0, 1'b1, 1'b1);     // no true class
    send_beat(16'sh0400, 1'b1, 1'b0, 1'b0);
    send_beat(-16'sh0200, 1'b1, 1'b1, 1'b1);    // two true classes
    send_beat(16'sh1234, 1'b1, 1'b1, 1'b1);     // single-class row
    // Row overflow: 34 beats, the last two dropped
    for (int i = 0; i < 34; i++)
      send_beat(16'($urandom), i == 5, i == 33, i == 33);
    drain();

    write_batch_rows(16'd0);                     // zero acts as one
    send_row(4, 2000, 1'b1);
    drain();
    write_batch_rows(16'hFFFF);
    send_row(3, 65535, 1'b0);
    send_row(3, 65535, 1'b1);
    drain();

    // Long receiver stall while the sender keeps going
    write_batch_rows(16'd4);
    hold_off = 400;
    burst = 1'b1;
    for (int r = 0; r < 4; r++) send_row(8, 3000, r == 3);
    burst = 1'b0;
    drain();

    // Random phases over several batch sizes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_batch_rows(16'd1);
        1: write_batch_rows(16'd3);
        2: write_batch_rows(16'($urandom_range(2, 65535)));
        default: write_batch_rows(16'd2);
      endcase
      rows = 0;
      while (rows < 5) begin
        burst = ($urandom_range(0, 4) == 0);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 32) : $urandom_range(1, 6);
        send_row(n, ($urandom_range(0, 1) == 1) ? 65535 : $urandom_range(0, 4000),
                 $urandom_range(0, 2) == 0 || rows == 4);
        if ($urandom_range(0, 5) == 0)
          send_beat(16'($urandom), $urandom_range(0, 1), 1'b0, 1'b1);
        rows++;
      end
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("softmax_cross_entropy_tb: clean");
    end else begin
      $display("softmax_cross_entropy_tb: errors");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("softmax_cross_entropy_tb: errors");
    $finish;
  end
endmodule
